[sv/first_fit_heap_allocator_macros.svh]
// Assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FFH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFH_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFH_ASSERT(label, clk, rst_n, prop, msg)
`define FFH_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[sv/ffha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_MEM    = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;

  // datapath commands
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;  // latch request, b = 0
  localparam logic [3:0] OP_RD       = 4'd2;  // issue header read at b
  localparam logic [3:0] OP_CAPT     = 4'd3;  // capture header read data
  localparam logic [3:0] OP_ADV      = 4'd4;  // b += span(h)
  localparam logic [3:0] OP_TAKE_A   = 4'd5;  // write taken header
  localparam logic [3:0] OP_TAKE_B   = 4'd6;  // write remainder header
  localparam logic [3:0] OP_APPEND   = 4'd7;  // write header at break, bump break
  localparam logic [3:0] OP_SETFREE  = 4'd8;  // write h|free at b
  localparam logic [3:0] OP_MSTART   = 4'd9;  // m = b, total = round4(size), next = b+span
  localparam logic [3:0] OP_MRD      = 4'd10; // read header at next
  localparam logic [3:0] OP_MABS     = 4'd11; // absorb header at next
  localparam logic [3:0] OP_MPUT     = 4'd12; // write merged header at m
  localparam logic [3:0] OP_MJUMP    = 4'd13; // b = next
  localparam logic [3:0] OP_RES      = 4'd14; // load result register
  localparam logic [3:0] OP_RESTART  = 4'd15; // b = 0 (merge pass)

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] res_status;
  } ffha_cmd_t;

  typedef struct packed {
    logic is_free;       // request is free
    logic in_chain;      // b < break
    logic next_in_chain; // next < break
    logic h_free;
    logic fits;          // h free and size >= req
    logic split;
    logic hn_free;
    logic addr_hit;      // b + 4 == addr
    logic no_room;
    logic merged;
  } ffha_sts_t;
endpackage

[sv/ffha_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_datapath
// Header memory, walk pointers and header arithmetic.
// ----------------------------------------------------------------------------
module ffha_datapath #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_command,
  input  logic [15:0]      in_request_bytes,
  input  logic [13:0]      in_block_address,
  input  ffha_pkg::ffha_cmd_t cmd,
  output ffha_pkg::ffha_sts_t sts,
  output logic [13:0]      res_offset,
  output logic [1:0]       res_status
);
  import ffha_pkg::*;
  localparam int AW = $clog2(HEAP_WORDS);
  // break plus the span of the largest request must fit without wrapping
  localparam int BW = (AW + 3 > 18) ? AW + 3 : 18;
  localparam logic [BW-1:0] HEAP_BYTES = BW'(HEAP_WORDS * 4);

  logic [16:0] mem [HEAP_WORDS];
  logic [16:0] rdata_r;
  logic        wen;
  logic [AW-1:0] waddr, raddr;
  logic [16:0] wdata;

  logic        cmd_r;
  logic [15:0] req_r;
  logic [13:0] addr_r;
  logic [BW-1:0] b_r, b_nxt, brk_r, brk_nxt, next_r, next_nxt, m_r, m_nxt;
  logic [BW-1:0] total_r, total_nxt;
  logic [16:0] h_r, h_nxt;
  logic        merged_r, merged_nxt;
  logic [13:0] res_off_r, res_off_nxt;
  logic [1:0]  res_st_r, res_st_nxt;

  function automatic logic [BW-1:0] r4(input logic [15:0] n);
    logic [16:0] s;
    s = {1'b0, n} + 17'd3;
    s[1:0] = 2'b00;
    return BW'(s);
  endfunction

  logic [BW-1:0] span_h, req4, spare, need, rem_at;
  assign span_h = BW'(4) + r4(h_r[15:0]);
  assign req4   = r4(req_r);
  assign spare  = r4(h_r[15:0]) - req4;
  assign need   = BW'(4) + req4;
  assign rem_at = b_r + need;

  always_comb begin
    sts.is_free       = cmd_r == CMD_FREE;
    sts.in_chain      = (b_r < brk_r);
    sts.next_in_chain = (next_r < brk_r);
    sts.h_free        = h_r[16];
    sts.fits          = h_r[16] && (h_r[15:0] >= req_r);
    sts.split         = spare > BW'(7);
    sts.hn_free       = rdata_r[16];
    sts.addr_hit      = (b_r + BW'(4)) == BW'(addr_r);
    sts.no_room       = (brk_r + need) > HEAP_BYTES;
    sts.merged        = merged_r;
  end

  always_comb begin
    wen = 1'b0; waddr = b_r[AW+1:2]; wdata = h_r; raddr = b_r[AW+1:2];
    b_nxt = b_r; brk_nxt = brk_r; next_nxt = next_r; m_nxt = m_r;
    total_nxt = total_r; h_nxt = h_r; merged_nxt = merged_r;
    res_off_nxt = res_off_r; res_st_nxt = res_st_r;
    case (cmd.op)
      OP_LOAD:    b_nxt = '0;
      OP_RD:      raddr = b_r[AW+1:2];
      OP_CAPT:    h_nxt = rdata_r;
      OP_ADV:     b_nxt = b_r + span_h;
      OP_TAKE_A: begin
        wen = 1'b1; waddr = b_r[AW+1:2];
        wdata = sts.split ? {1'b0, req_r} : {1'b0, h_r[15:0]};
      end
      OP_TAKE_B: begin
        wen = 1'b1; waddr = rem_at[AW+1:2];
        wdata = {1'b1, 16'(spare - BW'(4))};
      end
      OP_APPEND: begin
        wen = 1'b1; waddr = brk_r[AW+1:2]; wdata = {1'b0, req_r};
        b_nxt = brk_r; brk_nxt = brk_r + need;
      end
      OP_SETFREE: begin
        wen = 1'b1; waddr = b_r[AW+1:2]; wdata = {1'b1, h_r[15:0]};
      end
      OP_MSTART: begin
        m_nxt = b_r; total_nxt = r4(h_r[15:0]); next_nxt = b_r + span_h;
        merged_nxt = 1'b0;
      end
      OP_MRD:     raddr = next_r[AW+1:2];
      OP_MABS: begin
        total_nxt = total_r + BW'(4) + r4(rdata_r[15:0]);
        next_nxt = next_r + BW'(4) + r4(rdata_r[15:0]);
        merged_nxt = 1'b1;
      end
      OP_MPUT: begin
        wen = 1'b1; waddr = m_r[AW+1:2]; wdata = {1'b1, total_r[15:0]};
      end
      OP_MJUMP:   b_nxt = next_r;
      OP_RESTART: b_nxt = '0;
      OP_RES: begin
        res_st_nxt = cmd.res_status;
        res_off_nxt = (cmd.res_status == ST_ALLOCATED) ? 14'(b_r + BW'(4)) : 14'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r <= '0;
    end else begin
      brk_r <= brk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      cmd_r <= in_command; req_r <= in_request_bytes; addr_r <= in_block_address;
    end
    b_r <= b_nxt; next_r <= next_nxt; m_r <= m_nxt; total_r <= total_nxt;
    h_r <= h_nxt; merged_r <= merged_nxt;
    res_off_r <= res_off_nxt; res_st_r <= res_st_nxt;
  end

  assign res_offset = res_off_r;
  assign res_status = res_st_r;
endmodule

[sv/ffha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate, free and merge walks, plus the output valid register.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"
module ffha_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  ffha_pkg::ffha_sts_t sts,
  output ffha_pkg::ffha_cmd_t cmd
);
  import ffha_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_WAIT = 4'd2, S_CAPT = 4'd3,
                         S_DEC = 4'd4, S_SPLIT = 4'd5, S_MRD = 4'd6, S_MWAIT = 4'd7,
                         S_MCHK = 4'd8, S_MEND = 4'd9, S_RES = 4'd10, S_OUT = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       merge_r, merge_nxt;  // walking in merge pass
  logic       ovalid_r, ovalid_nxt;
  logic [1:0] rst_st;

  always_comb begin
    state_nxt = state_r; merge_nxt = merge_r; ovalid_nxt = ovalid_r;
    cmd.op = OP_NONE; cmd.res_status = ST_ALLOCATED; rst_st = ST_ALLOCATED;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD; merge_nxt = 1'b0; state_nxt = S_RD;
      end
      S_RD: begin
        if (!sts.in_chain) begin
          if (merge_r || sts.is_free) begin
            state_nxt = S_RES;
          end else if (sts.no_room) begin
            state_nxt = S_RES;
          end else begin
            cmd.op = OP_APPEND; state_nxt = S_RES;
          end
        end else begin
          cmd.op = OP_RD; state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_CAPT;
      S_CAPT: begin cmd.op = OP_CAPT; state_nxt = S_DEC; end
      S_DEC: begin
        if (merge_r) begin
          if (sts.h_free) begin cmd.op = OP_MSTART; state_nxt = S_MRD; end
          else begin cmd.op = OP_ADV; state_nxt = S_RD; end
        end else if (!sts.is_free) begin
          if (sts.fits) begin
            cmd.op = OP_TAKE_A;
            state_nxt = sts.split ? S_SPLIT : S_RES;
          end else begin cmd.op = OP_ADV; state_nxt = S_RD; end
        end else if (sts.addr_hit) begin
          cmd.op = OP_SETFREE; merge_nxt = 1'b1; state_nxt = S_OUT;
        end else begin cmd.op = OP_ADV; state_nxt = S_RD; end
      end
      S_OUT: begin cmd.op = OP_RESTART; state_nxt = S_RD; end
      S_SPLIT: begin cmd.op = OP_TAKE_B; state_nxt = S_RES; end
      S_MRD: begin
        if (sts.next_in_chain) begin cmd.op = OP_MRD; state_nxt = S_MWAIT; end
        else state_nxt = S_MEND;
      end
      // keep the read address on next so the read data holds for the check
      S_MWAIT: begin cmd.op = OP_MRD; state_nxt = S_MCHK; end
      S_MCHK: begin
        if (sts.hn_free) begin cmd.op = OP_MABS; state_nxt = S_MRD; end
        else state_nxt = S_MEND;
      end
      S_MEND: begin
        if (sts.merged) cmd.op = OP_MPUT;
        state_nxt = S_RES;
        merge_nxt = 1'b1;
      end
      S_RES: begin
        if (merge_r && sts.in_chain) begin
          // still walking merge chain: continue at next
          cmd.op = OP_MJUMP; state_nxt = S_RD;
        end else if (!ovalid_r || !out_stall) begin
          if (sts.is_free) rst_st = ST_FREED;
          else if (!sts.in_chain && sts.no_room && !merge_r)
            rst_st = ST_NO_MEM;
          cmd.op = OP_RES; cmd.res_status = rst_st;
          ovalid_nxt = 1'b1; state_nxt = S_IDLE; merge_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; merge_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; merge_r <= merge_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  `FFH_ASSERT(a_accept_idle, clk, rst_n, (in_valid && !in_stall) |=> (state_r == S_RD), "accept must start walk")
  `FFH_ASSERT(a_res_once, clk, rst_n, (cmd.op == OP_RES) |=> out_valid, "result not posted")
  `FFH_ASSERT_RST(a_reset_idle, clk, (!rst_n) |=> (!out_valid && state_r == S_IDLE), "reset state")
endmodule

[sv/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with split and coalescing over a header memory.
// A free adds a full merge walk of the chain. One request at a time: no new
// request is taken until the result of the last is posted. The walk uses the
// header memory with one write and one read port. Reset is synchronous: break
// cleared, header memory undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [15:0] in_request_bytes,
  input  logic [13:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_payload_offset,
  output logic [1:0]  out_status
);
  import ffha_pkg::*;
  ffha_cmd_t cmd;
  ffha_sts_t sts;
  logic [1:0] st_raw;

  ffha_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
                    .sts, .cmd);
  ffha_datapath #(.HEAP_WORDS(HEAP_WORDS)) u_dp (.clk, .rst_n, .in_command,
    .in_request_bytes, .in_block_address, .cmd, .sts, .res_offset(out_payload_offset),
    .res_status(st_raw));

  assign out_status = st_raw;
endmodule

[test/first_fit_heap_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives random allocate/free traffic into the heap allocator through
// valid/stall handshakes with random gaps and stalls on both channels.
// A behavioral model of the header chain predicts each response word,
// and the monitor checks every response against it in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int HEAP_WORDS = 4096;
  localparam int unsigned HEAP_BYTES = HEAP_WORDS * 4;

  // request kind, and how a pending free picks its address
  typedef enum logic [1:0] {K_ALLOC, K_FREE_LIVE, K_FREE_RAW} req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [15:0] bytes;
    logic [13:0] addr;
  } heap_req_t;

  typedef struct packed {
    logic [13:0] offset;
    logic [1:0]  status;
  } heap_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [15:0] in_request_bytes;
  logic [13:0] in_block_address;
  logic        out_valid;
  logic        out_stall;
  logic [13:0] out_payload_offset;
  logic [1:0]  out_status;

  heap_req_t   pending_reqs[$];
  heap_rsp_t   expected_rsps[$];
  logic [13:0] live_payloads[$];
  int          fail_count;
  int          n_alloc, n_nomem, n_free;
  bit          stim_done;
  int          in_gap, out_gap;
  bit          in_burst, out_burst;

  // model state
  logic [16:0] hdr_mem[HEAP_WORDS];
  int unsigned brk;

  first_fit_heap_allocator #(.HEAP_WORDS(HEAP_WORDS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_request_bytes(in_request_bytes),
    .in_block_address(in_block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_offset(out_payload_offset), .out_status(out_status)
  );

  function automatic int unsigned round4(int unsigned n);
    return (n + 3) & ~32'd3;
  endfunction

  function automatic int unsigned block_span(logic [16:0] h);
    return 4 + round4(h[15:0]);
  endfunction

  function automatic bit hdr_read(int unsigned b, output logic [16:0] h);
    h = '0;
    if (b >= brk || (b >> 2) >= HEAP_WORDS) return 0;
    h = hdr_mem[b >> 2];
    return 1;
  endfunction

  function automatic void hdr_write(int unsigned b, int unsigned h);
    if ((b >> 2) < HEAP_WORDS) hdr_mem[b >> 2] = h[16:0];
  endfunction

  function automatic void coalesce_chain();
    int unsigned b, nxt, total;
    logic [16:0] h, hn;
    bit merged;
    b = 0;
    while (hdr_read(b, h)) begin
      nxt = b + block_span(h);
      if (h[16]) begin
        total = round4(h[15:0]);
        merged = 0;
        while (hdr_read(nxt, hn) && hn[16]) begin
          total += block_span(hn);
          nxt += block_span(hn);
          merged = 1;
        end
        if (merged) hdr_write(b, 32'h10000 | (total & 32'hFFFF));
      end
      b = nxt;
    end
  endfunction

  function automatic heap_rsp_t heap_apply(logic cmd, logic [15:0] req, logic [13:0] addr);
    heap_rsp_t r;
    int unsigned b, size, spare, need;
    logic [16:0] h;
    b = 0;
    r.offset = '0;
    if (cmd == CMD_ALLOC) begin
      while (hdr_read(b, h)) begin
        size = h[15:0];
        if (h[16] && size >= req) begin
          spare = round4(size) - round4(req);
          if (spare > 7) begin
            hdr_write(b, req);
            hdr_write(b + 4 + round4(req), 32'h10000 | ((spare - 4) & 32'hFFFF));
          end else begin
            hdr_write(b, size);
          end
          r.offset = 14'(b + 4);
          r.status = ST_ALLOCATED;
          return r;
        end
        b += block_span(h);
      end
      need = 4 + round4(req);
      if (brk + need > HEAP_BYTES) begin
        r.status = ST_NO_MEM;
        return r;
      end
      b = brk;
      brk += need;
      hdr_write(b, req);
      r.offset = 14'(b + 4);
      r.status = ST_ALLOCATED;
      return r;
    end
    while (hdr_read(b, h)) begin
      if (b + 4 == addr) begin
        hdr_write(b, h | 17'h10000);
        coalesce_chain();
        break;
      end
      b += block_span(h);
    end
    r.status = ST_FREED;
    return r;
  endfunction

  function automatic int pick_gap(bit burst);
    if (burst) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 60);
  endfunction

  function automatic void queue_req(req_kind_t k, int unsigned bytes, int unsigned addr);
    heap_req_t q;
    q.kind = k;
    q.bytes = 16'(bytes);
    q.addr = 14'(addr);
    pending_reqs.push_back(q);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    heap_req_t q;
    heap_rsp_t r;
    int idx;
    logic [13:0] a;
    if (!rst_n) begin
      in_valid <= 0;
      in_command <= CMD_ALLOC;
      in_request_bytes <= '0;
      in_block_address <= '0;
      in_gap <= 0;
      in_burst <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        r = heap_apply(in_command, in_request_bytes, in_block_address);
        expected_rsps.push_back(r);
        if (in_command == CMD_ALLOC) begin
          if (r.status == ST_ALLOCATED) begin
            n_alloc++;
            live_payloads.push_back(r.offset);
          end else begin
            n_nomem++;
          end
        end else begin
          n_free++;
          foreach (live_payloads[i])
            if (live_payloads[i] == in_block_address) begin
              live_payloads.delete(i);
              break;
            end
        end
      end
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 63) == 0) in_burst <= ~in_burst;
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_reqs.size() > 0) begin
          q = pending_reqs.pop_front();
          in_command <= (q.kind == K_ALLOC) ? CMD_ALLOC : CMD_FREE;
          in_request_bytes <= q.bytes;
          a = q.addr;
          if (q.kind == K_FREE_LIVE && live_payloads.size() > 0) begin
            idx = $urandom_range(0, live_payloads.size() - 1);
            a = live_payloads[idx];
          end
          in_block_address <= a;
          in_valid <= 1;
          in_gap <= pick_gap(in_burst);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    heap_rsp_t e;
    if (!rst_n) begin
      out_stall <= 0;
      out_gap <= 0;
      out_burst <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response word: offset %0d status %0d",
                 out_payload_offset, out_status);
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_payload_offset !== e.offset) begin
            $error("payload_offset: expected %0d, actual %0d", e.offset, out_payload_offset);
            fail_count++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_status);
            fail_count++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) out_burst <= ~out_burst;
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap(out_burst);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned k, sz;
    fail_count = 0;
    n_alloc = 0;
    n_nomem = 0;
    n_free = 0;
    stim_done = 0;
    brk = 0;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed: zero, odd, max sizes, split, no split, merge, unknown and double free
    queue_req(K_FREE_RAW, 0, 4);          // free on empty heap
    queue_req(K_ALLOC, 0, 0);             // payload 4
    queue_req(K_ALLOC, 1, 0);             // payload 8
    queue_req(K_ALLOC, 65535, 16383);     // heap full
    queue_req(K_ALLOC, 100, 0);           // payload 16
    queue_req(K_ALLOC, 3, 0);             // payload 120
    queue_req(K_FREE_RAW, 65535, 16);     // free 100-byte block
    queue_req(K_ALLOC, 8, 0);             // split it
    queue_req(K_ALLOC, 85, 0);            // no split, takes remainder
    queue_req(K_FREE_RAW, 0, 16383);      // unknown address
    queue_req(K_FREE_RAW, 0, 18);         // misaligned, unknown
    queue_req(K_FREE_RAW, 0, 8);
    queue_req(K_FREE_RAW, 0, 8);          // double free
    queue_req(K_FREE_RAW, 0, 4);          // merges with neighbor
    queue_req(K_FREE_RAW, 0, 120);
    queue_req(K_ALLOC, 16376 - 140, 0);   // leaves 20 bytes below the heap end
    queue_req(K_ALLOC, 0, 0);
    queue_req(K_FREE_LIVE, 0, 0);
    queue_req(K_FREE_LIVE, 0, 0);
    queue_req(K_FREE_LIVE, 0, 0);
    queue_req(K_FREE_LIVE, 0, 0);
    queue_req(K_ALLOC, 16380, 0);

    for (k = 0; k < 1430; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          sz = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 255) : $urandom_range(256, 3000);
          queue_req(K_ALLOC, sz, $urandom_range(0, 16383));
        end
        10: queue_req(K_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 16383));
        11: queue_req(K_FREE_RAW, $urandom_range(0, 65535), $urandom_range(0, 16383));
        12: queue_req(K_FREE_RAW, $urandom_range(0, 65535), 4 * $urandom_range(1, 300));
        default: queue_req(K_FREE_LIVE, $urandom_range(0, 65535), $urandom_range(0, 16383));
      endcase
    end

    wait (pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d allocations, %0d out-of-memory replies and %0d frees,",
             n_alloc, n_nomem, n_free);
    $display("with random gaps and stalls on both handshakes.");
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("first_fit_heap_allocator_tb: PASS");
    end else begin
      $display("first_fit_heap_allocator_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #1000ms;
    $display("first_fit_heap_allocator_tb: FAIL");
    $finish;
  end
endmodule
